### design/lm_pkg.sv
// lm_pkg: shared types for the list median block.
// No dependencies.
package lm_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned MedianW = 33;
  localparam int unsigned CountW  = 7;

  typedef logic signed [ValueW-1:0]  value_t;
  typedef logic signed [MedianW-1:0] median_t;
  typedef logic [CountW-1:0]         count_out_t;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic ins;    // insert the broadcast word in order
    logic shift;  // move every word one cell toward the head
  } cell_ctl_t;

endpackage

### design/lm_cell.sv
// lm_cell: one slot of the sorted chain.
// Depends on lm_pkg.
module lm_cell (
  input  logic              clk_i,
  input  lm_pkg::cell_ctl_t ctl_i,
  input  logic              occ_i,
  input  lm_pkg::value_t    new_i,
  input  lm_pkg::value_t    left_i,
  input  logic              left_le_i,
  input  lm_pkg::value_t    right_i,
  output lm_pkg::value_t    value_o,
  output logic              le_o
);

  lm_pkg::value_t value_q, value_d;
  logic           keep;

  assign le_o = (value_q <= new_i);
  assign keep = occ_i && le_o;

  always_comb begin
    value_d = value_q;
    if (ctl_i.ins) begin
      if (keep) begin
        value_d = value_q;
      end else if (left_le_i) begin
        value_d = new_i;
      end else begin
        value_d = left_i;
      end
    end else if (ctl_i.shift) begin
      value_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

### design/list_median.sv
// list_median: median of a streamed list, kept in a chain of sorting cells.
// Back-to-back words are taken without a stall; busy_o stays low while a list streams.
// After the last word is taken, busy_o is high while the chain drains toward
// the head; done_o pulses, rising as busy_o falls, and cannot be held off.
// rst_ni clears count, overflow flag and control; cell contents are not reset.
// Depends on lm_pkg and lm_cell.
module list_median #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  lm_pkg::value_t      sample_value_i,
  input  logic                is_numeric_i,
  input  logic                last_element_i,
  output logic                done_o,
  output lm_pkg::median_t     median_value_o,
  output lm_pkg::count_out_t  numeric_count_o,
  output logic                overflowed_o
);

  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  localparam logic StIdle  = 1'b0;
  localparam logic StDrain = 1'b1;

  logic           state_q, state_d;
  logic [CW-1:0]  count_q, count_d;
  logic [CW-1:0]  pos_q, pos_d;
  logic           ovf_q, ovf_d;
  lm_pkg::value_t lo_q, lo_d;
  logic           done_q, done_d;
  lm_pkg::median_t med_q, med_d;
  lm_pkg::count_out_t cnt_out_q, cnt_out_d;
  logic           ovf_out_q, ovf_out_d;

  logic           accept, full, half_hit;
  logic [CW-1:0]  half;
  lm_pkg::cell_ctl_t ctl;

  lm_pkg::value_t vals [MAX_ITEMS];
  logic           les  [MAX_ITEMS];

  assign accept = start_i && (state_q == StIdle);
  assign full   = (count_q == CW'(MAX_ITEMS));
  assign half   = count_q >> 1;
  assign half_hit = (pos_q == half);

  assign ctl.ins   = accept && is_numeric_i && !full;
  assign ctl.shift = (state_q == StDrain);

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    lm_pkg::value_t left_v, right_v;
    logic           left_le;
    if (i == 0) begin : g_head
      assign left_v  = vals[0];
      assign left_le = 1'b1;
    end else begin : g_body
      assign left_v  = vals[i-1];
      assign left_le = les[i-1];
    end
    if (i == MAX_ITEMS - 1) begin : g_tail
      assign right_v = vals[i];
    end else begin : g_mid
      assign right_v = vals[i+1];
    end
    lm_cell u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .occ_i     (count_q > CW'(i)),
      .new_i     (sample_value_i),
      .left_i    (left_v),
      .left_le_i (left_le),
      .right_i   (right_v),
      .value_o   (vals[i]),
      .le_o      (les[i])
    );
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    pos_d     = pos_q;
    ovf_d     = ovf_q;
    lo_d      = lo_q;
    done_d    = 1'b0;
    med_d     = med_q;
    cnt_out_d = cnt_out_q;
    ovf_out_d = ovf_out_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (is_numeric_i) begin
            if (full) begin
              ovf_d = 1'b1;
            end else begin
              count_d = count_q + CW'(1);
            end
          end
          if (last_element_i) begin
            state_d = StDrain;
            pos_d   = '0;
          end
        end
      end
      StDrain: begin
        pos_d = pos_q + CW'(1);
        if (pos_q == half - CW'(1)) begin
          lo_d = vals[0];
        end
        if (half_hit) begin
          if (count_q == '0) begin
            med_d = '0;
          end else if (count_q[0]) begin
            med_d = {vals[0], 1'b0};
          end else begin
            med_d = lm_pkg::median_t'(lo_q) + lm_pkg::median_t'(vals[0]);
          end
          cnt_out_d = lm_pkg::count_out_t'(count_q);
          ovf_out_d = ovf_q;
          done_d    = 1'b1;
          count_d   = '0;
          ovf_d     = 1'b0;
          state_d   = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      ovf_q   <= 1'b0;
      done_q  <= 1'b0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      done_q  <= done_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q      <= lo_d;
    med_q     <= med_d;
    cnt_out_q <= cnt_out_d;
    ovf_out_q <= ovf_out_d;
  end

  assign busy_o          = (state_q == StDrain);
  assign done_o          = done_q;
  assign median_value_o  = med_q;
  assign numeric_count_o = cnt_out_q;
  assign overflowed_o    = ovf_out_q;

endmodule

### tb/tb_list_median.sv
// tb_list_median: checks list_median against its own sorted-list median predictor.
// Words are queued by the stimulus block, driven with random gaps, and results checked in order.
// Depends on lm_pkg and list_median.
`timescale 1ns / 1ps

module tb_list_median;

  localparam int unsigned MaxItems   = 64;
  localparam int unsigned RandWords  = 1650;
  localparam int unsigned DrainCycles = MaxItems / 2 + 8;

  typedef struct {
    lm_pkg::value_t val;
    logic           num;
    logic           last;
    bit             hold;
    int unsigned    gap;
  } list_word_t;

  typedef struct {
    lm_pkg::median_t    med;
    lm_pkg::count_out_t cnt;
    logic               ovf;
  } median_rec_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  lm_pkg::value_t     sample_value_i = '0;
  logic               is_numeric_i = 1'b0;
  logic               last_element_i = 1'b0;
  logic               busy_o;
  logic               done_o;
  lm_pkg::median_t    median_value_o;
  lm_pkg::count_out_t numeric_count_o;
  logic               overflowed_o;

  list_word_t  pend_words[$];
  median_rec_t results_due[$];
  list_word_t  cur_word;

  lm_pkg::value_t kept_vals[MaxItems];
  int unsigned    kept_n = 0;
  logic           dropped_any = 1'b0;

  int unsigned n_total = 0;
  int unsigned n_taken = 0;
  int unsigned n_results = 0;
  int unsigned n_ovf = 0;
  int unsigned n_empty = 0;
  int unsigned n_errs = 0;
  int unsigned wait_cnt = 0;
  bit          gap_armed = 1'b0;

  list_median #(
    .MAX_ITEMS(MaxItems)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .sample_value_i (sample_value_i),
    .is_numeric_i   (is_numeric_i),
    .last_element_i (last_element_i),
    .done_o         (done_o),
    .median_value_o (median_value_o),
    .numeric_count_o(numeric_count_o),
    .overflowed_o   (overflowed_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // sorted insert, then median of the kept words on the last one
  task automatic absorb_word(input list_word_t w);
    int unsigned pos;
    int unsigned h;
    median_rec_t r;
    if (w.num) begin
      if (kept_n >= MaxItems) begin
        dropped_any = 1'b1;
      end else begin
        pos = 0;
        while (pos < kept_n && kept_vals[pos] <= w.val) pos++;
        for (int unsigned i = kept_n; i > pos; i--) kept_vals[i] = kept_vals[i-1];
        kept_vals[pos] = w.val;
        kept_n++;
      end
    end
    if (w.last) begin
      r.med = '0;
      if (kept_n > 0) begin
        h = kept_n / 2;
        if (kept_n % 2) begin
          r.med = {kept_vals[h], 1'b0};
        end else begin
          r.med = {kept_vals[h-1][lm_pkg::ValueW-1], kept_vals[h-1]} +
                  {kept_vals[h][lm_pkg::ValueW-1], kept_vals[h]};
        end
      end
      r.cnt = lm_pkg::count_out_t'(kept_n);
      r.ovf = dropped_any;
      results_due.push_back(r);
      kept_n = 0;
      dropped_any = 1'b0;
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic lm_pkg::value_t pick_value(int unsigned style);
    lm_pkg::value_t v;
    case (style)
      0: v = $urandom;
      1: v = lm_pkg::value_t'(($urandom_range(0, 8) - 4) * 65536);
      2: begin
        case ($urandom_range(0, 6))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'h7FFF_FFFE;
          3: v = 32'h8000_0001;
          4: v = '0;
          5: v = '1;
          default: v = 32'h0000_0001;
        endcase
      end
      default: v = lm_pkg::value_t'($signed($urandom) >>> $urandom_range(0, 31));
    endcase
    return v;
  endfunction

  task automatic add_word(input lm_pkg::value_t v, input logic num, input logic last,
                          input bit hold, input int unsigned gap);
    list_word_t w;
    w.val = v;
    w.num = num;
    w.last = last;
    w.hold = hold;
    w.gap = gap;
    pend_words.push_back(w);
  endtask

  // n_num numeric words with some non-numeric noise mixed in
  task automatic add_list(input int unsigned n_num, input bit hold);
    int unsigned style;
    int unsigned k;
    bit          no_gaps;
    bit          skip_last;
    bit          first;
    style = $urandom_range(0, 3);
    no_gaps = ($urandom_range(0, 2) == 0);
    skip_last = ($urandom_range(0, 3) == 0) || (n_num == 0);
    first = 1'b1;
    k = 0;
    while (k < n_num) begin
      if ($urandom_range(0, 6) == 0) begin
        add_word($urandom, 1'b0, 1'b0, hold && first, no_gaps ? 0 : pick_gap());
      end else begin
        k++;
        add_word(pick_value(style), 1'b1, (k == n_num) && !skip_last, hold && first,
                 no_gaps ? 0 : pick_gap());
      end
      first = 1'b0;
    end
    if (skip_last) add_word($urandom, 1'b0, 1'b1, hold && first, no_gaps ? 0 : pick_gap());
  endtask

  // driver: start stays high across back-to-back words
  always @(posedge clk_i) begin
    bit   fire;
    logic nxt_start;
    if (rst_ni) begin
      fire = start_i && !busy_o;
      if (fire) begin
        absorb_word(cur_word);
        n_taken++;
      end
      if (fire || !start_i) begin
        nxt_start = 1'b0;
        if (pend_words.size() > 0) begin
          if (!gap_armed) begin
            wait_cnt = pend_words[0].gap;
            gap_armed = 1'b1;
          end
          if (wait_cnt > 0) begin
            wait_cnt--;
          end else if (!pend_words[0].hold || results_due.size() == 0) begin
            cur_word = pend_words.pop_front();
            gap_armed = 1'b0;
            nxt_start = 1'b1;
          end
        end
        start_i <= nxt_start;
        if (nxt_start) begin
          sample_value_i <= cur_word.val;
          is_numeric_i <= cur_word.num;
          last_element_i <= cur_word.last;
        end else begin
          sample_value_i <= $urandom;
          is_numeric_i <= 1'($urandom_range(0, 1));
          last_element_i <= 1'($urandom_range(0, 1));
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    median_rec_t e;
    if (rst_ni && done_o) begin
      n_results++;
      if (overflowed_o) n_ovf++;
      if (numeric_count_o == '0) n_empty++;
      if (results_due.size() == 0) begin
        $error("unexpected result: median_value %0d", median_value_o);
        n_errs++;
      end else begin
        e = results_due.pop_front();
        if (median_value_o !== e.med) begin
          $error("median_value: expected %0d, got %0d", e.med, median_value_o);
          n_errs++;
        end
        if (numeric_count_o !== e.cnt) begin
          $error("numeric_count: expected %0d, got %0d", e.cnt, numeric_count_o);
          n_errs++;
        end
        if (overflowed_o !== e.ovf) begin
          $error("overflowed: expected %0d, got %0d", e.ovf, overflowed_o);
          n_errs++;
        end
      end
    end
  end

  initial begin
    int unsigned r;
    int unsigned len;
    int unsigned n_lists;

    // empty list, single extremes, extreme pairs
    add_word(32'h1234_5678, 1'b0, 1'b1, 1'b0, 0);
    add_word(32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0, 0);
    add_word(32'h8000_0000, 1'b1, 1'b1, 1'b0, 1);
    add_word(32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 0);
    add_word(32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0, 0);
    add_word(32'h8000_0000, 1'b1, 1'b0, 1'b0, 0);
    add_word(32'h8000_0000, 1'b1, 1'b1, 1'b0, 2);
    add_word(32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 0);
    add_word(32'h8000_0000, 1'b1, 1'b1, 1'b0, 0);
    // odd count with duplicates, noise, and a non-numeric last word
    add_word(32'h0005_0000, 1'b1, 1'b0, 1'b0, 0);
    add_word(32'hDEAD_BEEF, 1'b0, 1'b0, 1'b0, 0);
    add_word(32'h0005_0000, 1'b1, 1'b0, 1'b0, 0);
    add_word(32'h0003_0000, 1'b1, 1'b0, 1'b0, 0);
    add_word(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 0);
    // even count, unordered, ties at the middle
    add_word(32'h000A_0000, 1'b1, 1'b0, 1'b0, 0);
    add_word(32'hFFFE_0000, 1'b1, 1'b0, 1'b0, 1);
    add_word(32'h0007_8000, 1'b1, 1'b0, 1'b0, 0);
    add_word(32'h0007_8000, 1'b1, 1'b1, 1'b0, 0);
    // zero and the smallest steps
    add_word(32'h0000_0000, 1'b1, 1'b0, 1'b0, 0);
    add_word(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 0);
    add_word(32'h0000_0001, 1'b1, 1'b1, 1'b0, 0);

    // full store, then one word past it
    add_list(MaxItems, 1'b1);
    add_list(MaxItems + 1, 1'b0);
    n_lists = 0;
    while (pend_words.size() < RandWords) begin
      r = $urandom_range(0, 99);
      if (r < 75) len = $urandom_range(0, 12);
      else if (r < 90) len = $urandom_range(13, 40);
      else len = $urandom_range(60, 80);
      add_list(len, (n_lists % 25) == 24);
      n_lists++;
    end
    n_total = pend_words.size();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_taken < n_total || results_due.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (results_due.size() > 0) begin
      $error("%0d results never arrived", results_due.size());
      n_errs++;
    end

    $display("run: %0d words driven, %0d lists checked (%0d with dropped words, %0d empty)",
             n_taken, n_results, n_ovf, n_empty);
    if (n_errs == 0) begin
      $display("tb_list_median: clean");
    end else begin
      $display("tb_list_median: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_list_median: errors");
    $finish;
  end

endmodule
